FILE: src/i2p_pkg.sv
// ----------------------------------------------------------------------------
// i2p_pkg
// Shared types, constants and helpers of the infix to postfix converter.
// ----------------------------------------------------------------------------
`default_nettype none

package i2p_pkg;

	// operator stack geometry
	localparam int STACK_DEPTH = 32;
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
	localparam int IDX_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

	// command queue and result queue depths (powers of two)
	localparam int CQ_DEPTH = 4;
	localparam int CQ_AW    = $clog2(CQ_DEPTH);
	localparam int RQ_DEPTH = 4;
	localparam int RQ_AW    = $clog2(RQ_DEPTH);

	// ASCII codes
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_MUL   = 8'h2A;
	localparam logic [7:0] CH_DIV   = 8'h2F;
	localparam logic [7:0] CH_OPEN  = 8'h28;
	localparam logic [7:0] CH_CLOSE = 8'h29;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UZ    = 8'h5A;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LZ    = 8'h7A;

	// status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_OVERFLOW = 2'd1;
	localparam logic [1:0] ST_UNM_CLS  = 2'd2;
	localparam logic [1:0] ST_UNM_OPN  = 2'd3;

	// stack entry codes
	typedef enum logic [2:0] {
		OP_OPEN  = 3'd0,
		OP_PLUS  = 3'd1,
		OP_MINUS = 3'd2,
		OP_MUL   = 3'd3,
		OP_DIV   = 3'd4
	} op_code_t;

	// item class from the front end
	typedef enum logic [2:0] {
		K_ALNUM = 3'd0,
		K_OP    = 3'd1,
		K_OPEN  = 3'd2,
		K_CLOSE = 3'd3,
		K_NONE  = 3'd4
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		op_code_t   op;
		logic [7:0] ch;
		logic       last;
	} cmd_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       char_valid;
		logic       expr_done;
		logic       run_last;
		logic [1:0] status;
	} res_t;

	// precedence: * / above + -, '(' lowest
	function automatic logic [1:0] prec_of(input op_code_t code);
		logic [1:0] p;
		p = 2'd0;
		if (code == OP_MUL || code == OP_DIV) p = 2'd2;
		else if (code == OP_PLUS || code == OP_MINUS) p = 2'd1;
		return p;
	endfunction

	function automatic logic [7:0] char_of(input op_code_t code);
		logic [7:0] c;
		unique case (code)
			OP_PLUS:  c = CH_PLUS;
			OP_MINUS: c = CH_MINUS;
			OP_MUL:   c = CH_MUL;
			OP_DIV:   c = CH_DIV;
			default:  c = CH_OPEN;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

FILE: src/i2p_front.sv
// ----------------------------------------------------------------------------
// i2p_front
// Classifies incoming characters and queues commands for the stack engine.
// ----------------------------------------------------------------------------
`default_nettype none

module i2p_front (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               push,
	output logic              full,
	input  wire  [7:0]        in_char,
	input  wire               expr_end,
	output logic              cmd_valid,
	output i2p_pkg::cmd_t     cmd,
	input  wire               cmd_pop
);
	import i2p_pkg::*;

	cmd_t               cq_mem [CQ_DEPTH];
	logic [CQ_AW-1:0]   wr_ptr_q;
	logic [CQ_AW-1:0]   rd_ptr_q;
	logic [CQ_AW:0]     cnt_q;
	cmd_t               cls;
	logic               is_alnum;
	logic               keep;
	logic               wr_en;
	logic               rd_en;

	// classify the incoming character
	always_comb begin
		is_alnum = (in_char >= CH_0 && in_char <= CH_9) ||
		           (in_char >= CH_UA && in_char <= CH_UZ) ||
		           (in_char >= CH_LA && in_char <= CH_LZ);
		cls.ch   = in_char;
		cls.last = expr_end;
		cls.op   = OP_OPEN;
		cls.kind = K_NONE;
		priority if (is_alnum) begin
			cls.kind = K_ALNUM;
		end else if (in_char == CH_PLUS) begin
			cls.kind = K_OP;
			cls.op   = OP_PLUS;
		end else if (in_char == CH_MINUS) begin
			cls.kind = K_OP;
			cls.op   = OP_MINUS;
		end else if (in_char == CH_MUL) begin
			cls.kind = K_OP;
			cls.op   = OP_MUL;
		end else if (in_char == CH_DIV) begin
			cls.kind = K_OP;
			cls.op   = OP_DIV;
		end else if (in_char == CH_OPEN) begin
			cls.kind = K_OPEN;
		end else if (in_char == CH_CLOSE) begin
			cls.kind = K_CLOSE;
		end else begin
			cls.kind = K_NONE;
		end
	end

	// ignored characters without end mark produce nothing: drop them here
	assign keep      = (cls.kind != K_NONE) || expr_end;
	assign full      = (cnt_q == (CQ_AW+1)'(CQ_DEPTH));
	assign wr_en     = push && !full && keep;
	assign cmd_valid = (cnt_q != '0);
	assign rd_en     = cmd_pop && cmd_valid;
	assign cmd       = cq_mem[rd_ptr_q];

	// command queue storage
	always_ff @(posedge clk) begin
		if (wr_en) begin
			cq_mem[wr_ptr_q] <= cls;
		end
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (rd_en) rd_ptr_q <= rd_ptr_q + 1'b1;
			cnt_q <= cnt_q + (CQ_AW+1)'(wr_en) - (CQ_AW+1)'(rd_en);
		end
	end

endmodule

`default_nettype wire

FILE: src/i2p_stack.sv
// ----------------------------------------------------------------------------
// i2p_stack
// Stack engine: one command at a time; pops one entry a cycle unless stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module i2p_stack (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               cmd_valid,
	input  i2p_pkg::cmd_t     cmd,
	output logic              cmd_pop,
	input  wire               res_full,
	output logic              res_push,
	output i2p_pkg::res_t     res
);
	import i2p_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_OP    = 5'b00010,
		S_CLOSE = 5'b00100,
		S_END   = 5'b01000,
		S_FIN   = 5'b10000
	} state_t;

	state_t            state_q, state_d;
	op_code_t          stk_mem [STACK_DEPTH];
	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]  open_q;
	op_code_t          op_q;
	logic              end_q;
	logic [1:0]        status_q;
	logic [7:0]        pend_ch_q;
	logic              pend_v_q;

	op_code_t          top;
	logic [IDX_W-1:0]  top_idx;
	logic              stk_full;
	logic              stk_nempty;
	logic              go;
	logic              emit_en;
	logic [7:0]        emit_ch;
	logic              stk_push;
	op_code_t          push_code;
	logic              stk_pop;
	logic              open_inc;
	logic              open_dec;
	logic              open_clr;
	logic              fin_wr;
	logic              latch;
	logic [1:0]        status_d;
	logic              pop_ok;
	logic              ovf;
	logic              unm;
	logic [CNT_W-1:0]  open_after;

	assign top_idx    = IDX_W'(cnt_q - 1'b1);
	assign top        = stk_mem[top_idx];
	assign stk_full   = (cnt_q == CNT_W'(STACK_DEPTH));
	assign stk_nempty = (cnt_q != '0);

	// status of a command is fixed up front from count and open-paren count
	always_comb begin
		pop_ok     = stk_nempty && top != OP_OPEN && prec_of(top) >= prec_of(cmd.op);
		ovf        = 1'b0;
		unm        = 1'b0;
		open_after = open_q;
		unique case (cmd.kind)
			K_OP: begin
				ovf = !pop_ok && stk_full;
			end
			K_OPEN: begin
				ovf        = stk_full;
				open_after = open_q + CNT_W'(!stk_full);
			end
			K_CLOSE: begin
				unm        = (open_q == '0);
				open_after = unm ? '0 : open_q - 1'b1;
			end
			default: begin
				ovf = 1'b0;
			end
		endcase
		priority if (ovf) status_d = ST_OVERFLOW;
		else if (unm) status_d = ST_UNM_CLS;
		else if (cmd.last && open_after != '0) status_d = ST_UNM_OPN;
		else status_d = ST_OK;
	end

	// sequencer
	always_comb begin
		state_d   = state_q;
		go        = !res_full;
		cmd_pop   = 1'b0;
		latch     = 1'b0;
		emit_en   = 1'b0;
		emit_ch   = char_of(top);
		stk_push  = 1'b0;
		push_code = op_q;
		stk_pop   = 1'b0;
		open_inc  = 1'b0;
		open_dec  = 1'b0;
		open_clr  = 1'b0;
		fin_wr    = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				go = cmd_valid && !res_full;
				if (go) begin
					cmd_pop = 1'b1;
					latch   = 1'b1;
					unique case (cmd.kind)
						K_ALNUM: begin
							emit_en = 1'b1;
							emit_ch = cmd.ch;
							state_d = S_END;
						end
						K_OP:    state_d = S_OP;
						K_OPEN: begin
							stk_push  = !stk_full;
							push_code = OP_OPEN;
							open_inc  = !stk_full;
							state_d   = S_END;
						end
						K_CLOSE: state_d = S_CLOSE;
						default: state_d = S_END;
					endcase
				end
			end
			S_OP: begin
				if (go) begin
					if (stk_nempty && top != OP_OPEN && prec_of(top) >= prec_of(op_q)) begin
						emit_en = 1'b1;
						stk_pop = 1'b1;
					end else begin
						stk_push = !stk_full;
						state_d  = S_END;
					end
				end
			end
			S_CLOSE: begin
				if (go) begin
					if (stk_nempty) begin
						stk_pop = 1'b1;
						if (top == OP_OPEN) begin
							open_dec = 1'b1;
							state_d  = S_END;
						end else begin
							emit_en = 1'b1;
						end
					end else begin
						open_clr = 1'b1;
						state_d  = S_END;
					end
				end
			end
			S_END: begin
				if (go) begin
					if (end_q && stk_nempty) begin
						stk_pop = 1'b1;
						if (top == OP_OPEN) open_dec = 1'b1;
						else emit_en = 1'b1;
					end else begin
						state_d = S_FIN;
					end
				end
			end
			S_FIN: begin
				if (go) begin
					fin_wr  = pend_v_q || end_q || (status_q != ST_OK);
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// result write: a held item goes out when the next one arrives or at finish
	always_comb begin
		res_push       = (emit_en && pend_v_q) || fin_wr;
		res.out_char   = pend_v_q ? pend_ch_q : 8'd0;
		res.char_valid = pend_v_q;
		res.expr_done  = fin_wr && end_q;
		res.run_last   = fin_wr;
		res.status     = status_q;
	end

	// operator stack storage
	always_ff @(posedge clk) begin
		if (stk_push) begin
			stk_mem[IDX_W'(cnt_q)] <= push_code;
		end
	end

	// command context and held item
	always_ff @(posedge clk) begin
		if (latch) begin
			op_q     <= cmd.op;
			end_q    <= cmd.last;
			status_q <= status_d;
		end
		if (emit_en) pend_ch_q <= emit_ch;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cnt_q    <= '0;
			open_q   <= '0;
			pend_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (stk_push) cnt_q <= cnt_q + 1'b1;
			else if (stk_pop) cnt_q <= cnt_q - 1'b1;
			priority if (open_clr) open_q <= '0;
			else if (open_inc) open_q <= open_q + 1'b1;
			else if (open_dec) open_q <= open_q - 1'b1;
			if (emit_en) pend_v_q <= 1'b1;
			else if (fin_wr) pend_v_q <= 1'b0;
		end
	end

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(STACK_DEPTH))
		else $error("stack count above depth");

	a_open_bound: assert property (@(posedge clk) disable iff (!arst_n)
		open_q <= cnt_q)
		else $error("open-paren count above stack count");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full)
		else $error("result write into full queue");

	a_fin_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN && !res_full) |=> (state_q == S_IDLE && !pend_v_q))
		else $error("held item not flushed at finish");
`endif

endmodule

`default_nettype wire

FILE: src/i2p_res_q.sv
// ----------------------------------------------------------------------------
// i2p_res_q
// Result queue between the stack engine and the output port.
// ----------------------------------------------------------------------------
`default_nettype none

module i2p_res_q (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               wr_en,
	input  i2p_pkg::res_t     wr_data,
	output logic              q_full,
	output logic              q_empty,
	input  wire               rd_en,
	output i2p_pkg::res_t     rd_data
);
	import i2p_pkg::*;

	res_t              rq_mem [RQ_DEPTH];
	logic [RQ_AW-1:0]  wr_ptr_q;
	logic [RQ_AW-1:0]  rd_ptr_q;
	logic [RQ_AW:0]    cnt_q;
	logic              do_wr;
	logic              do_rd;

	assign q_full  = (cnt_q == (RQ_AW+1)'(RQ_DEPTH));
	assign q_empty = (cnt_q == '0);
	assign do_wr   = wr_en && !q_full;
	assign do_rd   = rd_en && !q_empty;
	assign rd_data = rq_mem[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			rq_mem[wr_ptr_q] <= wr_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_rd) rd_ptr_q <= rd_ptr_q + 1'b1;
			cnt_q <= cnt_q + (RQ_AW+1)'(do_wr) - (RQ_AW+1)'(do_rd);
		end
	end

endmodule

`default_nettype wire

FILE: src/infix_to_postfix_converter.sv
// ----------------------------------------------------------------------------
// infix_to_postfix_converter
// Shunting-yard infix to postfix conversion with a 32-entry operator stack.
// ----------------------------------------------------------------------------
//  channel  | handshake        | payload
//  ---------+------------------+--------------------------------------------
//  input    | push / full      | in_char, expr_end
//  result   | pop / empty      | out_char, char_valid, expr_done, run_last,
//           |                  | status
//
// An item passes the engine states IDLE, END and FIN; an operator also passes
// OP (its own push) and a ')' passes CLOSE. The one-pop-per-cycle sequencer
// takes each stack entry off (operators emitted, a matched '(' and the
// end-of-expression drain) while the result queue is not full.
// Ignored characters without end mark are dropped in the front end.
// Reset clears the queues, stack count and sequencer; no clearing pass.
// A full result queue stalls the engine; the command queue keeps taking items
// until its four entries are used.
// ----------------------------------------------------------------------------
`default_nettype none

module infix_to_postfix_converter (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        push,
	output logic       full,
	input  wire  [7:0] in_char,
	input  wire        expr_end,
	output logic       empty,
	input  wire        pop,
	output logic [7:0] out_char,
	output logic       char_valid,
	output logic       expr_done,
	output logic       run_last,
	output logic [1:0] status
);
	import i2p_pkg::*;

	logic  cmd_valid;
	cmd_t  cmd;
	logic  cmd_pop;
	logic  res_full;
	logic  res_push;
	res_t  res_wr;
	res_t  res_rd;

	i2p_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.in_char   (in_char),
		.expr_end  (expr_end),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	i2p_stack u_stack (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.res_full  (res_full),
		.res_push  (res_push),
		.res       (res_wr)
	);

	i2p_res_q u_res_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_push),
		.wr_data (res_wr),
		.q_full  (res_full),
		.q_empty (empty),
		.rd_en   (pop),
		.rd_data (res_rd)
	);

	// result fields
	assign out_char   = res_rd.out_char;
	assign char_valid = res_rd.char_valid;
	assign expr_done  = res_rd.expr_done;
	assign run_last   = res_rd.run_last;
	assign status     = res_rd.status;

endmodule

`default_nettype wire
